// ----- design/gphc_pkg.sv -----
// ============================================================================
// gphc_pkg
// Shared types, codes and the CRC-32 byte step for the header patch block.
// ============================================================================
package gphc_pkg;

    // Header geometry
    localparam int unsigned HEADER_BYTES = 92;
    localparam logic [6:0]  HDR_LAST_OFF = 7'(HEADER_BYTES - 1);

    // Field offsets inside the header
    localparam logic [6:0] OFF_REV_LO     = 7'd8;
    localparam logic [6:0] OFF_REV_HI     = 7'd11;
    localparam logic [6:0] OFF_REV_ONE    = 7'd10;
    localparam logic [6:0] OFF_HSIZE_LO   = 7'd12;
    localparam logic [6:0] OFF_HSIZE_HI   = 7'd15;
    localparam logic [6:0] OFF_HCRC_LO    = 7'd16;
    localparam logic [6:0] OFF_HCRC_HI    = 7'd19;
    localparam logic [6:0] OFF_BACKUP_LO  = 7'd32;
    localparam logic [6:0] OFF_BACKUP_HI  = 7'd39;
    localparam logic [6:0] OFF_LUSABLE_LO = 7'd48;
    localparam logic [6:0] OFF_LUSABLE_HI = 7'd55;
    localparam logic [6:0] OFF_ESIZE_LO   = 7'd84;
    localparam logic [6:0] OFF_ESIZE_HI   = 7'd87;
    localparam logic [6:0] OFF_LCRC_LO    = 7'd88;
    localparam logic [6:0] OFF_LCRC_HI    = 7'd91;

    // Expected nonzero byte of each checked field (its other bytes are zero)
    localparam logic [7:0] REV_BYTE   = 8'h01;
    localparam logic [7:0] HSIZE_BYTE = 8'h5C;
    localparam logic [7:0] ESIZE_BYTE = 8'h80;

    // Reserved sectors at the end of the disk, per sector size
    localparam logic [63:0] LBA_BACKUP_SUB = 64'd1;
    localparam logic [63:0] LBA_RSV_512    = 64'd34;
    localparam logic [63:0] LBA_RSV_4K     = 64'd6;

    // CRC-32, reflected
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // Configuration register indexes
    localparam logic CFG_SECTOR_MODE = 1'b0;
    localparam logic CFG_DISK_SIZE   = 1'b1;

    // Sector size modes
    localparam logic [1:0] SECTOR_512 = 2'd0;
    localparam logic [1:0] SECTOR_4K  = 2'd1;

    // Input modes
    localparam logic MODE_ENTRY  = 1'b0;
    localparam logic MODE_HEADER = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_HDR_BYTE = 2'd0;
    localparam logic [1:0] KIND_LIST_CRC = 2'd1;
    localparam logic [1:0] KIND_HDR_CRC  = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_REV     = 3'd1;
    localparam logic [2:0] ST_BAD_HSIZE   = 3'd2;
    localparam logic [2:0] ST_BAD_ESIZE   = 3'd3;
    localparam logic [2:0] ST_BAD_SECTOR  = 3'd4;
    localparam logic [2:0] ST_NO_ENTRIES  = 3'd5;

    // Result queue
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic       last_entry;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [6:0]  byte_offset;
        logic [31:0] crc_value;
        logic [2:0]  status;
        logic        last_of_run;
    } out_item_t;

    // One byte of reflected CRC-32, bit at a time
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- design/gpt_header_patch_crc.sv -----
// ============================================================================
// gpt_header_patch_crc
// Streaming patcher for a primary partition-table header with CRC-32 update.
// ============================================================================
//
// Accepts one request per clock. Entry-array bytes (mode 0) feed a reflected
// CRC-32; the byte flagged last_entry yields one list-CRC result. Then 92
// header bytes (mode 1) each yield one patched byte; the final header byte
// also yields a header-CRC/status result, so that request produces two
// results. All per-byte work (field check, field substitution, one CRC byte
// step) happens in the accept cycle; results land in a 4-entry result queue
// and are visible on the m_ side from the next cycle on. s_ready is high while
// the queue has two free slots (three or more queued results hold s_ready low).
// With m_ready held high the block takes one request per cycle as long as the
// stream makes no more results than requests; the extra result at the end of a
// header can stall the input unless a request with no result (an entry byte
// that does not close its list) drains the queue first, so headers that follow
// each other with no such byte in between see the input stall at their ends.
// When the consumer stalls, s_ready drops as soon as more than two results are
// queued. Derived LBA values (size-1, size-34, size-6) are computed when
// CFG_DISK_SIZE is written, so configure only while no header is in flight.
module gpt_header_patch_crc (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [63:0]          cfg_wdata,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  gphc_pkg::in_item_t   s_item,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output gphc_pkg::out_item_t  m_item
);
    import gphc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers (with precomputed LBA values)
    // ------------------------------------------------------------------
    logic [1:0]  sector_mode_reg;
    logic [63:0] backup_lba_reg;
    logic [63:0] lu512_lba_reg;
    logic [63:0] lu4k_lba_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sector_mode_reg <= SECTOR_512;
            backup_lba_reg  <= 64'd0 - LBA_BACKUP_SUB;
            lu512_lba_reg   <= 64'd0 - LBA_RSV_512;
            lu4k_lba_reg    <= 64'd0 - LBA_RSV_4K;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_SECTOR_MODE: begin
                    sector_mode_reg <= cfg_wdata[1:0];
                end
                CFG_DISK_SIZE: begin
                    backup_lba_reg <= cfg_wdata - LBA_BACKUP_SUB;
                    lu512_lba_reg  <= cfg_wdata - LBA_RSV_512;
                    lu4k_lba_reg   <= cfg_wdata - LBA_RSV_4K;
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stream state
    // ------------------------------------------------------------------
    logic [31:0] running_crc_reg, running_crc_next;
    logic [31:0] list_crc_reg,    list_crc_next;
    logic        list_done_reg,   list_done_next;
    logic [6:0]  hdr_off_reg,     hdr_off_next;
    logic [2:0]  error_code_reg,  error_code_next;

    // Result queue
    out_item_t           q_mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    logic      accept;
    logic      pop;
    logic [1:0] push_n;
    out_item_t res0, res1;

    assign s_ready = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign accept  = s_valid && s_ready;
    assign m_valid = (count_reg != '0);
    assign pop     = m_valid && m_ready;
    assign m_item  = q_mem[rd_ptr_reg];

    // ------------------------------------------------------------------
    // Per-request processing
    // ------------------------------------------------------------------
    logic [6:0]  off;
    logic [7:0]  b;
    logic        chk_fail;
    logic [2:0]  chk_code;
    logic [2:0]  err_now;
    logic [7:0]  patched;
    logic [31:0] crc_base;
    logic [31:0] crc_step;
    logic [2:0]  final_status;

    assign off = hdr_off_reg;
    assign b   = s_item.data_byte;

    // Header field checks use the raw input byte
    always_comb begin
        chk_fail = 1'b0;
        chk_code = ST_OK;
        priority if (off >= OFF_REV_LO && off <= OFF_REV_HI) begin
            chk_fail = (b != ((off == OFF_REV_ONE) ? REV_BYTE : 8'h00));
            chk_code = ST_BAD_REV;
        end else if (off >= OFF_HSIZE_LO && off <= OFF_HSIZE_HI) begin
            chk_fail = (b != ((off == OFF_HSIZE_LO) ? HSIZE_BYTE : 8'h00));
            chk_code = ST_BAD_HSIZE;
        end else if (off >= OFF_ESIZE_LO && off <= OFF_ESIZE_HI) begin
            chk_fail = (b != ((off == OFF_ESIZE_LO) ? ESIZE_BYTE : 8'h00));
            chk_code = ST_BAD_ESIZE;
        end else begin
        end
    end

    // Keep the first failure only
    assign err_now = (error_code_reg == ST_OK && chk_fail) ? chk_code : error_code_reg;

    // Field substitution; all patched fields start on an 8-byte boundary,
    // so the low offset bits select the little-endian byte
    always_comb begin
        patched = b;
        priority if (off >= OFF_HCRC_LO && off <= OFF_HCRC_HI) begin
            patched = 8'h00;
        end else if (off >= OFF_BACKUP_LO && off <= OFF_BACKUP_HI) begin
            patched = backup_lba_reg[{off[2:0], 3'b000} +: 8];
        end else if (off >= OFF_LUSABLE_LO && off <= OFF_LUSABLE_HI) begin
            // unsupported sector size: pass the byte unchanged
            if (sector_mode_reg == SECTOR_512) begin
                patched = lu512_lba_reg[{off[2:0], 3'b000} +: 8];
            end else if (sector_mode_reg == SECTOR_4K) begin
                patched = lu4k_lba_reg[{off[2:0], 3'b000} +: 8];
            end
        end else if (off >= OFF_LCRC_LO && off <= OFF_LCRC_HI) begin
            patched = list_crc_reg[{off[1:0], 3'b000} +: 8];
        end else begin
        end
    end

    // Header restarts the CRC at its first byte; entry bytes chain on
    always_comb begin
        if (s_item.mode == MODE_HEADER && off == 7'd0) begin
            crc_base = CRC_INIT;
        end else begin
            crc_base = running_crc_reg;
        end
    end

    assign crc_step = crc32_byte(crc_base,
                                 (s_item.mode == MODE_HEADER) ? patched : b);

    always_comb begin
        final_status = err_now;
        if (final_status == ST_OK && sector_mode_reg != SECTOR_512
            && sector_mode_reg != SECTOR_4K) begin
            final_status = ST_BAD_SECTOR;
        end
        if (final_status == ST_OK && !list_done_reg) begin
            final_status = ST_NO_ENTRIES;
        end
    end

    // Next state and results
    always_comb begin
        running_crc_next = running_crc_reg;
        list_crc_next    = list_crc_reg;
        list_done_next   = list_done_reg;
        hdr_off_next     = hdr_off_reg;
        error_code_next  = error_code_reg;
        push_n           = 2'd0;
        res0             = '0;
        res1             = '0;

        if (accept) begin
            if (s_item.mode == MODE_ENTRY) begin
                // drop entry bytes that arrive inside a header
                if (off == 7'd0) begin
                    list_done_next = s_item.last_entry;
                    if (s_item.last_entry) begin
                        list_crc_next    = ~crc_step;
                        running_crc_next = CRC_INIT;
                        res0.kind        = KIND_LIST_CRC;
                        res0.crc_value   = ~crc_step;
                        res0.status      = ST_OK;
                        res0.last_of_run = 1'b1;
                        push_n           = 2'd1;
                    end else begin
                        running_crc_next = crc_step;
                    end
                end
            end else begin
                res0.kind        = KIND_HDR_BYTE;
                res0.out_byte    = patched;
                res0.byte_offset = off;
                if (off != HDR_LAST_OFF) begin
                    running_crc_next = crc_step;
                    hdr_off_next     = off + 7'd1;
                    error_code_next  = err_now;
                    res0.last_of_run = 1'b1;
                    push_n           = 2'd1;
                end else begin
                    res1.kind        = KIND_HDR_CRC;
                    res1.crc_value   = ~crc_step;
                    res1.status      = final_status;
                    res1.last_of_run = 1'b1;
                    push_n           = 2'd2;
                    // return to reset state for the next header
                    running_crc_next = CRC_INIT;
                    list_crc_next    = 32'd0;
                    list_done_next   = 1'b0;
                    hdr_off_next     = 7'd0;
                    error_code_next  = ST_OK;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_crc_reg <= CRC_INIT;
            list_crc_reg    <= 32'd0;
            list_done_reg   <= 1'b0;
            hdr_off_reg     <= 7'd0;
            error_code_reg  <= ST_OK;
        end else begin
            running_crc_reg <= running_crc_next;
            list_crc_reg    <= list_crc_next;
            list_done_reg   <= list_done_next;
            hdr_off_reg     <= hdr_off_next;
            error_code_reg  <= error_code_next;
        end
    end

    // ------------------------------------------------------------------
    // Result queue: up to two writes and one read per cycle
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            q_mem[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2) begin
            q_mem[wr_ptr_reg + QPTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_n);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + QCNT_W'(push_n) - QCNT_W'(pop);
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_offset_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hdr_off_reg <= HDR_LAST_OFF)
        else $error("header offset out of range");

    a_header_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_item.mode == MODE_HEADER && hdr_off_reg == HDR_LAST_OFF)
        |=> (hdr_off_reg == 7'd0 && error_code_reg == ST_OK && !list_done_reg
             && count_reg >= QCNT_W'(2)))
        else $error("header end did not restore state or queue both results");

    a_crc_result_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_item.kind == KIND_HDR_CRC || m_item.kind == KIND_LIST_CRC))
        |-> m_item.last_of_run)
        else $error("CRC result not flagged last of run");

endmodule

// ----- test/gpt_header_patch_crc_tb.sv -----
// ============================================================================
// gpt_header_patch_crc_tb
// Self-checking bench for the partition-table header patcher.
// ============================================================================
//
// Streams entry-array lists and 92-byte headers into the block, runs its own
// predictor of the patch and the two CRC-32 sums, and compares every result
// field by field in order. Configuration changes happen between phases while
// the block is idle. The sender runs in random bursts, and the receiver stalls
// on its own pattern, including one long hold-off that backs the block up.
module gpt_header_patch_crc_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gphc_pkg::*;

    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          SETTLE_TICKS = 16;
    localparam int          PHASE_ITEMS  = 330;
    localparam int          HOLDOFF_LEN  = 300;
    // Sector size modes that the block does not support
    localparam logic [1:0]  SECTOR_RSV2  = 2'd2;
    localparam logic [1:0]  SECTOR_RSV3  = 2'd3;

    // DUT connections, all driven from time zero
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [63:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_item    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_item;

    gpt_header_patch_crc dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Requests waiting to be driven, and the results the predictor owes
    in_item_t    byte_feed[$];
    out_item_t   due_results[$];
    int          fail_count = 0;
    int          fed_count  = 0;

    // Predictor state: a private copy of the block's registers and sums
    logic [31:0] crc_tab [256];
    logic [31:0] run_crc     = CRC_INIT;
    logic [31:0] list_sum    = '0;
    logic        list_closed = 1'b0;
    logic [6:0]  hdr_off     = '0;
    logic [2:0]  hdr_err     = ST_OK;
    logic [1:0]  sec_mode    = SECTOR_512;
    logic [63:0] disk_secs   = '0;

    // Table-driven reflected CRC-32, one byte per call
    function automatic logic [31:0] crc_adv(input logic [31:0] crc, input logic [7:0] b);
        return (crc >> 8) ^ crc_tab[crc[7:0] ^ b];
    endfunction

    function automatic void build_crc_tab();
        logic [31:0] c;
        for (int i = 0; i < 256; i++) begin
            c = 32'(i);
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            crc_tab[i] = c;
        end
    endfunction

    // Record the first failed header check only
    function automatic void flag_error(input logic [2:0] code);
        if (hdr_err == ST_OK) begin
            hdr_err = code;
        end
    endfunction

    // Advance the predictor by one accepted request and queue what it yields
    function automatic void patch_and_crc(input in_item_t it);
        out_item_t   r;
        logic [7:0]  o;
        logic [6:0]  off;
        logic [2:0]  st;
        logic [63:0] lba;
        int          idx;
        r = '0;
        if (it.mode == MODE_ENTRY) begin
            // Drop entry bytes that land inside a header
            if (hdr_off != 0) begin
                return;
            end
            list_closed = 1'b0;
            run_crc = crc_adv(run_crc, it.data_byte);
            if (!it.last_entry) begin
                return;
            end
            list_sum    = ~run_crc;
            list_closed = 1'b1;
            run_crc     = CRC_INIT;
            r.kind        = KIND_LIST_CRC;
            r.crc_value   = list_sum;
            r.last_of_run = 1'b1;
            due_results.push_back(r);
            return;
        end

        off = hdr_off;
        // First header byte restarts the sum, discarding any open list
        if (off == 0) begin
            run_crc = CRC_INIT;
        end

        // Field checks look at the raw input byte
        if (off >= OFF_REV_LO && off <= OFF_REV_HI) begin
            if (it.data_byte != (off == OFF_REV_ONE ? REV_BYTE : 8'h00)) begin
                flag_error(ST_BAD_REV);
            end
        end else if (off >= OFF_HSIZE_LO && off <= OFF_HSIZE_HI) begin
            if (it.data_byte != (off == OFF_HSIZE_LO ? HSIZE_BYTE : 8'h00)) begin
                flag_error(ST_BAD_HSIZE);
            end
        end else if (off >= OFF_ESIZE_LO && off <= OFF_ESIZE_HI) begin
            if (it.data_byte != (off == OFF_ESIZE_LO ? ESIZE_BYTE : 8'h00)) begin
                flag_error(ST_BAD_ESIZE);
            end
        end

        // Substitute the patched fields, little-endian
        o = it.data_byte;
        if (off >= OFF_HCRC_LO && off <= OFF_HCRC_HI) begin
            o = 8'h00;
        end else if (off >= OFF_BACKUP_LO && off <= OFF_BACKUP_HI) begin
            idx = int'(off - OFF_BACKUP_LO);
            lba = disk_secs - LBA_BACKUP_SUB;
            o   = lba[idx*8 +: 8];
        end else if (off >= OFF_LUSABLE_LO && off <= OFF_LUSABLE_HI) begin
            idx = int'(off - OFF_LUSABLE_LO);
            // Unsupported sector sizes leave the field as it came in
            if (sec_mode == SECTOR_512) begin
                lba = disk_secs - LBA_RSV_512;
                o   = lba[idx*8 +: 8];
            end else if (sec_mode == SECTOR_4K) begin
                lba = disk_secs - LBA_RSV_4K;
                o   = lba[idx*8 +: 8];
            end
        end else if (off >= OFF_LCRC_LO && off <= OFF_LCRC_HI) begin
            idx = int'(off - OFF_LCRC_LO);
            o   = list_sum[idx*8 +: 8];
        end

        run_crc = crc_adv(run_crc, o);
        r.kind        = KIND_HDR_BYTE;
        r.out_byte    = o;
        r.byte_offset = off;

        if (off != HDR_LAST_OFF) begin
            hdr_off       = off + 7'd1;
            r.last_of_run = 1'b1;
            due_results.push_back(r);
            return;
        end

        r.last_of_run = 1'b0;
        due_results.push_back(r);

        // Closing result: header CRC plus the first problem found
        st = hdr_err;
        if (st == ST_OK && sec_mode != SECTOR_512 && sec_mode != SECTOR_4K) begin
            st = ST_BAD_SECTOR;
        end
        if (st == ST_OK && !list_closed) begin
            st = ST_NO_ENTRIES;
        end
        r             = '0;
        r.kind        = KIND_HDR_CRC;
        r.crc_value   = ~run_crc;
        r.status      = st;
        r.last_of_run = 1'b1;
        due_results.push_back(r);

        run_crc     = CRC_INIT;
        list_sum    = '0;
        list_closed = 1'b0;
        hdr_off     = '0;
        hdr_err     = ST_OK;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: pop requests in bursts, with random gaps in between
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = $urandom_range(1, 40);
            gap_left   = 0;
        end else if (!s_valid || s_ready) begin
            // Previous request is gone (or there was none): pick the next move
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (byte_feed.size() > 0) begin
                s_item  <= byte_feed.pop_front();
                s_valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    // Close the burst; about half the bursts run back to back
                    burst_left = $urandom_range(1, 40);
                    gap_left   = $urandom_range(0, 1) ? $urandom_range(1, 10) : 0;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall style picked at random among four; one long hold-off once
    // the feed has backed up, so the block's result queue fills and s_ready drops
    // ------------------------------------------------------------------------
    int rx_tick       = 0;
    int rx_style      = 0;
    int stall_left    = 0;
    bit holdoff_done  = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_tick++;
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!holdoff_done && byte_feed.size() > 40) begin
                holdoff_done = 1'b1;
                stall_left   = HOLDOFF_LEN;
                m_ready <= 1'b0;
            end else begin
                if (rx_tick % 48 == 0) begin
                    rx_style = $urandom_range(0, 3);
                end
                case (rx_style)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= ($urandom_range(0, 3) != 0);
                    end
                    2: begin
                        m_ready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        m_ready <= rx_tick[2];
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on each accepted request, then check each accepted
    // result against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                patch_and_crc(s_item);
            end
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result: kind %0d crc %h", m_item.kind, m_item.crc_value);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (m_item.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_item.kind);
                        fail_count++;
                    end
                    if (m_item.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %h, got %h", want.out_byte, m_item.out_byte);
                        fail_count++;
                    end
                    if (m_item.byte_offset !== want.byte_offset) begin
                        $error("byte_offset: expected %0d, got %0d",
                               want.byte_offset, m_item.byte_offset);
                        fail_count++;
                    end
                    if (m_item.crc_value !== want.crc_value) begin
                        $error("crc_value: expected %h, got %h", want.crc_value, m_item.crc_value);
                        fail_count++;
                    end
                    if (m_item.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_item.status);
                        fail_count++;
                    end
                    if (m_item.last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %0d, got %0d",
                               want.last_of_run, m_item.last_of_run);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure
    int cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("gpt_header_patch_crc_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void offer(input logic mode, input logic [7:0] b, input logic last);
        byte_feed.push_back(in_item_t'{mode, b, last});
        fed_count++;
    endfunction

    // One entry list of n random bytes; flag the final byte only when closed
    function automatic void queue_list(input int n, input bit closed);
        for (int i = 0; i < n; i++) begin
            offer(MODE_ENTRY, 8'($urandom), closed && (i == n - 1));
        end
    endfunction

    // A 92-byte header with valid check fields, then the requested flaws:
    // bit 0 breaks the revision, bit 1 the header size, bit 2 the entry size.
    // noise_at > 0 slips a stray entry byte in front of that header offset.
    function automatic void queue_header(input logic [2:0] flaws, input int noise_at);
        logic [7:0] hb [HEADER_BYTES];
        for (int i = 0; i < HEADER_BYTES; i++) begin
            hb[i] = 8'($urandom);
        end
        for (int i = OFF_REV_LO; i <= OFF_REV_HI; i++) begin
            hb[i] = (i == OFF_REV_ONE) ? REV_BYTE : 8'h00;
        end
        for (int i = OFF_HSIZE_LO; i <= OFF_HSIZE_HI; i++) begin
            hb[i] = (i == OFF_HSIZE_LO) ? HSIZE_BYTE : 8'h00;
        end
        for (int i = OFF_ESIZE_LO; i <= OFF_ESIZE_HI; i++) begin
            hb[i] = (i == OFF_ESIZE_LO) ? ESIZE_BYTE : 8'h00;
        end
        if (flaws[0]) begin
            hb[$urandom_range(OFF_REV_LO, OFF_REV_HI)] ^= 8'($urandom_range(1, 255));
        end
        if (flaws[1]) begin
            hb[$urandom_range(OFF_HSIZE_LO, OFF_HSIZE_HI)] ^= 8'($urandom_range(1, 255));
        end
        if (flaws[2]) begin
            hb[$urandom_range(OFF_ESIZE_LO, OFF_ESIZE_HI)] ^= 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < HEADER_BYTES; i++) begin
            if (noise_at > 0 && i == noise_at) begin
                offer(MODE_ENTRY, 8'($urandom), 1'($urandom_range(0, 1)));
            end
            offer(MODE_HEADER, hb[i], 1'($urandom_range(0, 1)));
        end
    endfunction

    // One random record: mostly a closed list followed by a clean header,
    // with missing, doubled and abandoned lists, flawed fields and stray bytes
    function automatic void queue_record();
        int pick;
        int n_lists;
        pick    = $urandom_range(0, 99);
        n_lists = (pick < 10) ? 0 : ((pick < 22) ? 2 : 1);
        for (int k = 0; k < n_lists; k++) begin
            queue_list(($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 12), 1'b1);
        end
        if ($urandom_range(0, 9) == 0) begin
            queue_list($urandom_range(1, 6), 1'b0);
        end
        queue_header(($urandom_range(0, 99) < 20) ? 3'($urandom_range(1, 7)) : 3'b000,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(1, HEADER_BYTES - 1) : 0);
    endfunction

    task automatic write_reg(input logic idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_SECTOR_MODE) begin
            sec_mode = val[1:0];
        end else begin
            disk_secs = val;
        end
    endtask

    // Hold until every request is out and every result is back, then let the
    // pipeline drain past any request that yields no result
    task automatic wait_idle();
        while (byte_feed.size() != 0 || s_valid || due_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic set_config(input logic [1:0] mode, input logic [63:0] size);
        logic [63:0] w;
        w      = {$urandom, $urandom};
        w[1:0] = mode;
        write_reg(CFG_SECTOR_MODE, w);
        write_reg(CFG_DISK_SIZE, size);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    logic [1:0]  ph_mode [6] = '{SECTOR_512, SECTOR_4K, SECTOR_RSV2,
                                 SECTOR_RSV3, SECTOR_4K, SECTOR_512};
    logic [63:0] ph_size [6];

    initial begin
        build_crc_tab();
        ph_size = '{64'd0, '1, 64'd1, 64'd34, 64'd6, 64'd0};
        ph_size[5] = {$urandom, $urandom};

        aresetn = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: single-byte lists at both byte extremes, a longer list,
        // a new list right after a closed one, then a header with a stray
        // entry byte in the middle that must be dropped
        set_config(SECTOR_512, {$urandom, $urandom});
        offer(MODE_ENTRY, 8'h00, 1'b1);
        offer(MODE_ENTRY, 8'hFF, 1'b0);
        offer(MODE_ENTRY, 8'hA5, 1'b0);
        offer(MODE_ENTRY, 8'h00, 1'b1);
        offer(MODE_ENTRY, 8'hFF, 1'b1);
        queue_header(3'b000, 40);
        // Header with no list in front of it
        queue_header(3'b000, 0);
        wait_idle();

        // Random phases, walking the sector modes and the size extremes
        for (int p = 0; p < 6; p++) begin
            set_config(ph_mode[p], ph_size[p]);
            fed_count = 0;
            while (fed_count < PHASE_ITEMS) begin
                queue_record();
            end
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("gpt_header_patch_crc_tb: clean");
        end else begin
            $display("gpt_header_patch_crc_tb: errors");
        end
        $finish;
    end

endmodule
